// File: hdl/preemptive_priority_scheduler_assert.svh
// Assertion macros for the priority scheduler.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define PPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when cond holds, result must hold in the next cycle.
`define PPS_ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

// File: hdl/pps_pkg.sv
// Shared types and codes for the priority scheduler.
// No dependencies; imported by pps_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int TIME_W = 16;

    typedef enum logic [2:0] {
        ST_ACCEPTED,
        ST_FULL,
        ST_IDLE,
        ST_RAN,
        ST_DONE
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_RUN
    } cell_op_t;

    typedef struct packed {
        logic [7:0]        pid;
        logic [7:0]        prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] run;
        logic [TIME_W-1:0] response;
    } entry_t;

    // Broadcast to every cell of the queue each cycle.
    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/pps_cell.sv
// One slot of the sorted ready queue; shifts toward or away from the head.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pps_pkg::cell_ctrl_t ctrl,
    input  wire pps_pkg::entry_t    prev_ent,
    input  wire logic               prev_valid,
    input  wire logic               prev_keep,
    input  wire pps_pkg::entry_t    next_ent,
    input  wire logic               next_valid,
    output pps_pkg::entry_t         ent,
    output logic                    valid,
    output logic                    keep
);
    import pps_pkg::*;

    entry_t ent_reg, ent_next;
    logic   valid_reg, valid_next;

    // Entry stays in place on insert if it sorts at or before the newcomer.
    assign keep = valid_reg && (ent_reg.prio <= ctrl.ent.prio);

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        ent_next   = ctrl.ent;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        ent_next   = prev_ent;
                        valid_next = prev_valid;
                    end
                end
            end
            CELL_POP:
            begin
                ent_next   = next_ent;
                valid_next = next_valid;
            end
            CELL_RUN:
            begin
                if (IS_HEAD)
                    ent_next = ctrl.ent;
            end
            default:
            begin
                ent_next   = ent_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent   = ent_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// File: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: sorted ready queue built as a chain of cells.
// Result is registered: it appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle; insert, run and pop each take one
// shift step of the cell chain; input stalls only while a result waits unread.
// Reset clears all queue valid bits, the time counter and the output valid.
// Depends on pps_pkg, pps_cell and preemptive_priority_scheduler_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "preemptive_priority_scheduler_assert.svh"

module preemptive_priority_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // process_id[7:0], priority_req[15:8], burst[31:16]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // process_id_res[7:0], finish_time[23:8],
                                        // turnaround[39:24], waiting[55:40], response[71:56]
    output logic [2:0]       m_tuser    // status[2:0]
);
    import pps_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    entry_t                 cell_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_keep;
    cell_ctrl_t             ctrl;

    logic [TIME_W-1:0] time_reg, time_next;
    logic              m_valid_reg;
    logic [71:0]       m_data_reg;
    status_t           m_status_reg;

    logic              s_fire, is_arrival, full;
    entry_t            head, head_upd, new_ent;
    logic [TIME_W-1:0] run_inc, resp_new, tat, wt;
    logic              done;
    status_t           status_c;
    logic [71:0]       data_c;

    assign s_fire     = s_tvalid && s_tready;
    assign s_tready   = !m_valid_reg || m_tready;
    assign is_arrival = s_tuser[0];
    assign full       = cell_valid[QUEUE_DEPTH-1];
    assign head       = cell_ent[0];

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                pps_cell #(.IS_HEAD(1'b1)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .prev_ent   (ctrl.ent),
                    .prev_valid (1'b0),
                    .prev_keep  (1'b1),
                    .next_ent   (cell_ent[1]),
                    .next_valid (cell_valid[1]),
                    .ent        (cell_ent[0]),
                    .valid      (cell_valid[0]),
                    .keep       (cell_keep[0])
                );
            end
            else if (k == QUEUE_DEPTH-1)
            begin : g_last
                pps_cell #(.IS_HEAD(1'b0)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .prev_ent   (cell_ent[k-1]),
                    .prev_valid (cell_valid[k-1]),
                    .prev_keep  (cell_keep[k-1]),
                    .next_ent   (cell_ent[k]),
                    .next_valid (1'b0),
                    .ent        (cell_ent[k]),
                    .valid      (cell_valid[k]),
                    .keep       (cell_keep[k])
                );
            end
            else
            begin : g_mid
                pps_cell #(.IS_HEAD(1'b0)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .prev_ent   (cell_ent[k-1]),
                    .prev_valid (cell_valid[k-1]),
                    .prev_keep  (cell_keep[k-1]),
                    .next_ent   (cell_ent[k+1]),
                    .next_valid (cell_valid[k+1]),
                    .ent        (cell_ent[k]),
                    .valid      (cell_valid[k]),
                    .keep       (cell_keep[k])
                );
            end
        end
    endgenerate

    // Head run bookkeeping for a tick.
    assign time_next = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
    assign run_inc   = (head.run == TIME_MAX) ? head.run : head.run + TIME_W'(1);
    assign resp_new  = (head.run == '0) ? (time_reg - head.arrival) : head.response;
    assign done      = (run_inc >= head.burst);
    assign tat       = time_next - head.arrival;
    assign wt        = (tat >= head.burst) ? (tat - head.burst) : '0;

    always_comb
    begin
        new_ent.pid      = s_tdata[7:0];
        new_ent.prio     = s_tdata[15:8];
        new_ent.arrival  = time_reg;
        new_ent.burst    = s_tdata[31:16];
        new_ent.run      = '0;
        new_ent.response = '0;

        head_upd          = head;
        head_upd.run      = run_inc;
        head_upd.response = resp_new;
    end

    always_comb
    begin
        ctrl.op  = CELL_HOLD;
        ctrl.ent = new_ent;
        if (s_fire)
        begin
            if (is_arrival)
            begin
                if (!full)
                    ctrl.op = CELL_INSERT;
            end
            else if (cell_valid[0])
            begin
                if (done)
                    ctrl.op = CELL_POP;
                else
                begin
                    ctrl.op  = CELL_RUN;
                    ctrl.ent = head_upd;
                end
            end
        end
    end

    always_comb
    begin
        status_c = ST_IDLE;
        data_c   = '0;
        if (is_arrival)
            status_c = full ? ST_FULL : ST_ACCEPTED;
        else if (cell_valid[0])
        begin
            data_c[7:0] = head.pid;
            if (done)
            begin
                status_c      = ST_DONE;
                data_c[23:8]  = time_next;
                data_c[39:24] = tat;
                data_c[55:40] = wt;
                data_c[71:56] = resp_new;
            end
            else
                status_c = ST_RAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire && !is_arrival)
                time_reg <= time_next;
            if (s_fire)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_data_reg   <= data_c;
            m_status_reg <= status_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `PPS_ASSERT(a_queue_packed, clk, rst_n,
        ((cell_valid + QUEUE_DEPTH'(1)) & cell_valid) == '0,
        "queue valid bits not packed at head")
    `PPS_ASSERT(a_time_monotonic, clk, rst_n, time_reg >= $past(time_reg),
        "time counter went backward")
    `PPS_ASSERT_NEXT(a_arrival_status, clk, rst_n, s_fire && is_arrival && !full,
        m_tvalid && (m_tuser == ST_ACCEPTED), "accepted arrival not reported")
    `PPS_ASSERT_NEXT(a_tick_status, clk, rst_n, s_fire && !is_arrival && cell_valid[0],
        m_tvalid && (m_tuser == ST_RAN || m_tuser == ST_DONE), "busy tick did not run head")

endmodule

`default_nettype wire
